// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion helpers, empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons)

`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ===== rtl/spi_pkg.sv =====
// ----------------------------------------------------------------------------
// Segment pair intersection package
// Widths, beat types and stage types shared by the pipeline modules.
// ----------------------------------------------------------------------------
package spi_pkg;

	localparam int COORD_WIDTH        = 24;
	localparam int POSITION_FRAC_BITS = 16;
	localparam int MARGIN_BITS        = 16;
	localparam int OWNER_WIDTH        = 16;

	localparam int POS_WIDTH   = POSITION_FRAC_BITS + 1;
	localparam int DIFF_WIDTH  = COORD_WIDTH + 1;
	localparam int PROD_WIDTH  = 2 * COORD_WIDTH + 1;
	localparam int CROSS_WIDTH = 2 * COORD_WIDTH + 2;
	localparam int MAG_WIDTH   = CROSS_WIDTH - 1;
	localparam int QUOT_BITS   =
		(POSITION_FRAC_BITS > MARGIN_BITS) ? POSITION_FRAC_BITS : MARGIN_BITS;

	// s1..s3 front, s4..s5 normalize, one stage per quotient bit, one result stage
	localparam int FRONT_STAGES = 3;
	localparam int NORM_STAGES  = 2;
	localparam int NUM_STAGES   = FRONT_STAGES + NORM_STAGES + QUOT_BITS + 1;

	typedef struct packed {
		logic signed [COORD_WIDTH-1:0] first_start_x;
		logic signed [COORD_WIDTH-1:0] first_start_z;
		logic signed [COORD_WIDTH-1:0] first_end_x;
		logic signed [COORD_WIDTH-1:0] first_end_z;
		logic signed [COORD_WIDTH-1:0] second_start_x;
		logic signed [COORD_WIDTH-1:0] second_start_z;
		logic signed [COORD_WIDTH-1:0] second_end_x;
		logic signed [COORD_WIDTH-1:0] second_end_z;
		logic [OWNER_WIDTH-1:0]        first_owner;
		logic [OWNER_WIDTH-1:0]        second_owner;
	} req_t;

	typedef struct packed {
		logic                 crosses;
		logic [POS_WIDTH-1:0] first_position;
		logic [POS_WIDTH-1:0] second_position;
	} rsp_t;

	typedef struct packed {
		logic signed [DIFF_WIDTH-1:0] c0;
		logic signed [DIFF_WIDTH-1:0] c2;
		logic signed [DIFF_WIDTH-1:0] p0;
		logic signed [DIFF_WIDTH-1:0] p2;
		logic signed [DIFF_WIDTH-1:0] h0;
		logic signed [DIFF_WIDTH-1:0] h2;
		logic                         rej;
	} diff_t;

	typedef struct packed {
		logic signed [PROD_WIDTH-1:0] h2p0;
		logic signed [PROD_WIDTH-1:0] h0p2;
		logic signed [PROD_WIDTH-1:0] c2h0;
		logic signed [PROD_WIDTH-1:0] c0h2;
		logic signed [PROD_WIDTH-1:0] c2p0;
		logic signed [PROD_WIDTH-1:0] c0p2;
		logic                         rej;
	} prod_t;

	typedef struct packed {
		logic signed [CROSS_WIDTH-1:0] r;
		logic signed [CROSS_WIDTH-1:0] x;
		logic signed [CROSS_WIDTH-1:0] s;
		logic                          rej;
	} cross_t;

	typedef struct packed {
		logic signed [CROSS_WIDTH-1:0] n1;
		logic signed [CROSS_WIDTH-1:0] n2;
		logic [MAG_WIDTH-1:0]          den;
		logic                          rej;
	} norm_t;

	typedef struct packed {
		logic [MAG_WIDTH-1:0] den;
		logic [MAG_WIDTH-1:0] rem1;
		logic [MAG_WIDTH-1:0] rem2;
		logic [QUOT_BITS-1:0] q1;
		logic [QUOT_BITS-1:0] q2;
		logic                 neg1;
		logic                 neg2;
		logic                 ge1;
		logic                 ge2;
		logic                 eq1;
		logic                 eq2;
		logic                 rej;
	} div_t;

endpackage

// ===== rtl/spi_front.sv =====
// ----------------------------------------------------------------------------
// Segment pair front end
// Edge vectors, partial products and cross products over three stages.
// ----------------------------------------------------------------------------
module spi_front
	import spi_pkg::*;
(
	input  logic                    clk,
	input  logic [FRONT_STAGES-1:0] en,
	input  req_t                    req,
	output cross_t                  xprod
);

	diff_t  diff_s1;
	prod_t  prod_s2;
	cross_t cross_s3;

	always_ff @(posedge clk) begin
		if (en[0]) begin
			diff_s1.c0  <= DIFF_WIDTH'(req.first_end_x) - DIFF_WIDTH'(req.first_start_x);
			diff_s1.c2  <= DIFF_WIDTH'(req.first_end_z) - DIFF_WIDTH'(req.first_start_z);
			diff_s1.p0  <= DIFF_WIDTH'(req.second_start_x) - DIFF_WIDTH'(req.second_end_x);
			diff_s1.p2  <= DIFF_WIDTH'(req.second_start_z) - DIFF_WIDTH'(req.second_end_z);
			diff_s1.h0  <= DIFF_WIDTH'(req.first_start_x) - DIFF_WIDTH'(req.second_start_x);
			diff_s1.h2  <= DIFF_WIDTH'(req.first_start_z) - DIFF_WIDTH'(req.second_start_z);
			diff_s1.rej <= (req.first_owner == req.second_owner);
		end
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			prod_s2.h2p0 <= PROD_WIDTH'(diff_s1.h2) * PROD_WIDTH'(diff_s1.p0);
			prod_s2.h0p2 <= PROD_WIDTH'(diff_s1.h0) * PROD_WIDTH'(diff_s1.p2);
			prod_s2.c2h0 <= PROD_WIDTH'(diff_s1.c2) * PROD_WIDTH'(diff_s1.h0);
			prod_s2.c0h2 <= PROD_WIDTH'(diff_s1.c0) * PROD_WIDTH'(diff_s1.h2);
			prod_s2.c2p0 <= PROD_WIDTH'(diff_s1.c2) * PROD_WIDTH'(diff_s1.p0);
			prod_s2.c0p2 <= PROD_WIDTH'(diff_s1.c0) * PROD_WIDTH'(diff_s1.p2);
			prod_s2.rej  <= diff_s1.rej;
		end
	end

	always_ff @(posedge clk) begin
		if (en[2]) begin
			cross_s3.r   <= CROSS_WIDTH'(prod_s2.h2p0) - CROSS_WIDTH'(prod_s2.h0p2);
			cross_s3.x   <= CROSS_WIDTH'(prod_s2.c2h0) - CROSS_WIDTH'(prod_s2.c0h2);
			cross_s3.s   <= CROSS_WIDTH'(prod_s2.c2p0) - CROSS_WIDTH'(prod_s2.c0p2);
			cross_s3.rej <= prod_s2.rej;
		end
	end

	assign xprod = cross_s3;

endmodule

// ===== rtl/spi_norm.sv =====
// ----------------------------------------------------------------------------
// Segment pair normalize
// Sign fix to a positive denominator, then range flags and divider seed.
// ----------------------------------------------------------------------------
module spi_norm
	import spi_pkg::*;
(
	input  logic                   clk,
	input  logic [NORM_STAGES-1:0] en,
	input  cross_t                 xprod,
	output div_t                   seed
);

	norm_t norm_s4;
	div_t  seed_s5;

	logic                 s_neg;
	logic                 n1_neg;
	logic                 n2_neg;
	logic [MAG_WIDTH-1:0] n1_mag;
	logic [MAG_WIDTH-1:0] n2_mag;
	logic                 n1_ge;
	logic                 n2_ge;

	assign s_neg = xprod.s[CROSS_WIDTH-1];

	always_ff @(posedge clk) begin
		if (en[0]) begin
			norm_s4.n1  <= s_neg ? xprod.r : -xprod.r;
			norm_s4.n2  <= s_neg ? xprod.x : -xprod.x;
			norm_s4.den <= MAG_WIDTH'(s_neg ? -xprod.s : xprod.s);
			norm_s4.rej <= xprod.rej || (xprod.s == '0);
		end
	end

	assign n1_neg = norm_s4.n1[CROSS_WIDTH-1];
	assign n2_neg = norm_s4.n2[CROSS_WIDTH-1];
	assign n1_mag = MAG_WIDTH'(norm_s4.n1);
	assign n2_mag = MAG_WIDTH'(norm_s4.n2);
	assign n1_ge  = !n1_neg && (n1_mag >= norm_s4.den);
	assign n2_ge  = !n2_neg && (n2_mag >= norm_s4.den);

	always_ff @(posedge clk) begin
		if (en[1]) begin
			seed_s5.den  <= norm_s4.den;
			seed_s5.rem1 <= (n1_neg || n1_ge) ? '0 : n1_mag;
			seed_s5.rem2 <= (n2_neg || n2_ge) ? '0 : n2_mag;
			seed_s5.q1   <= '0;
			seed_s5.q2   <= '0;
			seed_s5.neg1 <= n1_neg;
			seed_s5.neg2 <= n2_neg;
			seed_s5.ge1  <= n1_ge;
			seed_s5.ge2  <= n2_ge;
			seed_s5.eq1  <= !n1_neg && (n1_mag == norm_s4.den);
			seed_s5.eq2  <= !n2_neg && (n2_mag == norm_s4.den);
			seed_s5.rej  <= norm_s4.rej;
		end
	end

	assign seed = seed_s5;

endmodule

// ===== rtl/spi_div_step.sv =====
// ----------------------------------------------------------------------------
// Segment pair divider step
// One restoring division stage: one quotient bit for each segment.
// ----------------------------------------------------------------------------
module spi_div_step
	import spi_pkg::*;
(
	input  logic clk,
	input  logic en,
	input  div_t din,
	output div_t dout
);

	div_t stage_sn;

	logic [MAG_WIDTH:0] den_ext;
	logic [MAG_WIDTH:0] t1;
	logic [MAG_WIDTH:0] t2;
	logic               b1;
	logic               b2;

	assign den_ext = {1'b0, din.den};
	assign t1      = {din.rem1, 1'b0};
	assign t2      = {din.rem2, 1'b0};
	assign b1      = (t1 >= den_ext);
	assign b2      = (t2 >= den_ext);

	always_ff @(posedge clk) begin
		if (en) begin
			stage_sn      <= din;
			stage_sn.rem1 <= b1 ? MAG_WIDTH'(t1 - den_ext) : MAG_WIDTH'(t1);
			stage_sn.rem2 <= b2 ? MAG_WIDTH'(t2 - den_ext) : MAG_WIDTH'(t2);
			stage_sn.q1   <= {din.q1[QUOT_BITS-2:0], b1};
			stage_sn.q2   <= {din.q2[QUOT_BITS-2:0], b2};
		end
	end

	assign dout = stage_sn;

endmodule

// ===== rtl/spi_result.sv =====
// ----------------------------------------------------------------------------
// Segment pair result stage
// Margin register, saturated positions and the exact margin test.
// ----------------------------------------------------------------------------
module spi_result
	import spi_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [MARGIN_BITS-1:0] cfg_wdata,
	input  logic                   en,
	input  div_t                   din,
	output rsp_t                   rsp
);

	localparam logic [MARGIN_BITS:0] MARGIN_ONE = (MARGIN_BITS + 1)'(1 << MARGIN_BITS);
	localparam logic [POS_WIDTH-1:0] POS_ONE    = POS_WIDTH'(1 << POSITION_FRAC_BITS);

	logic [MARGIN_BITS-1:0] margin_q;
	rsp_t                   rsp_s1;

	logic [MARGIN_BITS:0] hi_lim;
	logic                 in1;
	logic                 in2;

	function automatic logic [POS_WIDTH-1:0] seg_position(
		input logic                 neg,
		input logic                 ge,
		input logic [QUOT_BITS-1:0] q
	);
		logic [POS_WIDTH-1:0] pos;
		if (neg) begin
			pos = '0;
		end else if (ge) begin
			pos = POS_ONE;
		end else begin
			pos = {1'b0, q[QUOT_BITS-1 -: POSITION_FRAC_BITS]};
		end
		return pos;
	endfunction

	function automatic logic seg_in_range(
		input logic                   neg,
		input logic                   ge,
		input logic                   eq,
		input logic [QUOT_BITS-1:0]   q,
		input logic [MAG_WIDTH-1:0]   rem,
		input logic [MARGIN_BITS-1:0] m,
		input logic [MARGIN_BITS:0]   lim
	);
		logic [MARGIN_BITS:0] qm;
		logic                 exact;
		logic                 low_ok;
		logic                 high_ok;
		qm      = {1'b0, q[QUOT_BITS-1 -: MARGIN_BITS]};
		exact   = ((q << MARGIN_BITS) == '0) && (rem == '0);
		low_ok  = ge || (qm >= {1'b0, m});
		high_ok = ge ? (eq && (m == '0)) : ((qm < lim) || ((qm == lim) && exact));
		return !neg && low_ok && high_ok;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			margin_q <= '0;
		end else if (cfg_we) begin
			margin_q <= cfg_wdata;
		end
	end

	assign hi_lim = MARGIN_ONE - {1'b0, margin_q};
	assign in1 = seg_in_range(din.neg1, din.ge1, din.eq1, din.q1, din.rem1, margin_q, hi_lim);
	assign in2 = seg_in_range(din.neg2, din.ge2, din.eq2, din.q2, din.rem2, margin_q, hi_lim);

	always_ff @(posedge clk) begin
		if (en) begin
			if (din.rej) begin
				rsp_s1 <= '0;
			end else begin
				rsp_s1.crosses         <= in1 && in2;
				rsp_s1.first_position  <= seg_position(din.neg1, din.ge1, din.q1);
				rsp_s1.second_position <= seg_position(din.neg2, din.ge2, din.q2);
			end
		end
	end

	assign rsp = rsp_s1;

endmodule

// ===== rtl/segment_pair_intersection.sv =====
// ----------------------------------------------------------------------------
// Segment pair intersection
// Each input beat passes the front, normalize, divider and result stages to a result beat.
// Throughput: one beat per cycle; a stage holds only while it and every later
// stage are full and the output is stalled. Reset clears valid bits and margin.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module segment_pair_intersection
	import spi_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [MARGIN_BITS-1:0] cfg_wdata,
	input  logic                   req_valid,
	output logic                   req_ready,
	input  req_t                   req,
	output logic                   rsp_valid,
	input  logic                   rsp_ready,
	output rsp_t                   rsp
);

	localparam int DIV_BASE = FRONT_STAGES + NORM_STAGES;
	localparam logic [POS_WIDTH-1:0] POS_ONE = POS_WIDTH'(1 << POSITION_FRAC_BITS);

	logic [NUM_STAGES-1:0] vld_q;
	logic [NUM_STAGES-1:0] vld_in;
	logic [NUM_STAGES-1:0] en;

	cross_t xprod;
	div_t   chain [QUOT_BITS+1];

	// a stage loads when the output is ready or any stage from it to the output has room
	for (genvar k = 0; k < NUM_STAGES; k++) begin : g_en
		assign en[k] = rsp_ready || !(&vld_q[NUM_STAGES-1:k]);
	end

	assign vld_in = {vld_q[NUM_STAGES-2:0], req_valid};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			for (int k = 0; k < NUM_STAGES; k++) begin
				if (en[k]) begin
					vld_q[k] <= vld_in[k];
				end
			end
		end
	end

	assign req_ready = en[0];
	assign rsp_valid = vld_q[NUM_STAGES-1];

	spi_front u_front (
		.clk   (clk),
		.en    (en[FRONT_STAGES-1:0]),
		.req   (req),
		.xprod (xprod)
	);

	spi_norm u_norm (
		.clk   (clk),
		.en    (en[DIV_BASE-1:FRONT_STAGES]),
		.xprod (xprod),
		.seed  (chain[0])
	);

	for (genvar i = 0; i < QUOT_BITS; i++) begin : g_div
		spi_div_step u_step (
			.clk  (clk),
			.en   (en[DIV_BASE+i]),
			.din  (chain[i]),
			.dout (chain[i+1])
		);
	end

	spi_result u_result (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.en        (en[NUM_STAGES-1]),
		.din       (chain[QUOT_BITS]),
		.rsp       (rsp)
	);

	`ASSERT_IMPLIES(a_ready_follows_sink, clk, arst_n, rsp_ready, req_ready)
	`ASSERT_IMPLIES(a_room_when_drained, clk, arst_n, !rsp_valid, req_ready)
	`ASSERT_NEXT(a_full_holds_result, clk, arst_n, !req_ready, rsp_valid)
	`ASSERT_IMPLIES(a_first_sat_exact, clk, arst_n, rsp_valid, rsp.first_position <= POS_ONE)
	`ASSERT_IMPLIES(a_second_sat_exact, clk, arst_n, rsp_valid, rsp.second_position <= POS_ONE)

endmodule
